// File: design/lfo_pkg.sv
package lfo_pkg;

  localparam int PHASE_W    = 32;
  localparam int SAMPLE_W   = 16;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 1;

  localparam logic [31:0] LFSR_SEED = 32'h2545F491;
  localparam logic [31:0] LFSR_TAPS = 32'h80200003;
  localparam logic [15:0] DEPTH_UNITY = 16'd32768;

  localparam logic signed [SAMPLE_W-1:0] VAL_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] VAL_MIN = 16'sh8000;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_SELECT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_TRIGGER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_COEFF = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_GAIN   = 3'd5;

  // Waveform codes
  localparam logic [2:0] WAVE_SINE     = 3'd0;
  localparam logic [2:0] WAVE_TRIANGLE = 3'd1;
  localparam logic [2:0] WAVE_SAW      = 3'd2;
  localparam logic [2:0] WAVE_SQUARE   = 3'd3;
  localparam logic [2:0] WAVE_RANDOM   = 3'd4;
  localparam logic [2:0] WAVE_HOLD     = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAVE,
    ST_DEPTH,
    ST_OLD,
    ST_NEW,
    ST_DONE
  } lfo_state_t;

  typedef logic [SAMPLE_W-2:0] sine_rom_t [0:SINE_DEPTH];

  // Quarter-wave sine table, polynomial evaluated in Q16 at elaboration
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint x, x2, t, u, v, w, y, s;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x  = (longint'(i) * 65536) / SINE_DEPTH;
      x2 = (x * x + 32768) >> 16;
      t  = (4640 * x2 + 32768) >> 16;
      u  = 42048 - t;
      v  = (u * x2 + 32768) >> 16;
      w  = 102944 - v;
      y  = (w * x + 32768) >> 16;
      s  = (y * 32768 + 32768) >> 16;
      if (s > 32767) s = 32767;
      rom[i] = (SAMPLE_W-1)'(s);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

// File: design/lfo_waveform_generator_unit.sv
// Low-frequency oscillator, one sample tick per input request.
// Input channel (in_*): one request per sample tick; in_tdata[0] is note_on.
// Result channel (out_*): one request per tick carrying the signed Q1.15
// modulation value in out_tdata.
// Configuration channel (cfg_*): cfg_index selects phase_step, phase_offset,
// wave_select, key_trigger, smooth_coeff or depth_gain; cfg_ready is always
// high. Write registers only while no tick is in flight.
// Timing: a tick is taken in the idle state and passes through the wave,
// depth, old-value, new-value and done states before its result is offered.
// The sequence is set by the single shared 17x18 multiplier, used in turn for
// the depth gain, the old-value term and the new-value term of the smoother.
// The result sits in an output register: a new tick is taken while it waits.
// If the receiver stalls long enough that the next result is ready before the
// previous one was taken, the sequencer holds in its last step until the
// output register frees up; no result is dropped or repeated.
// Reset (rst_n low, synchronous) clears the phase, the smoother and the output
// valid, reloads the noise generator seed and sets depth_gain to unity.
module lfo_waveform_generator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] note_on, [7:1] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] lfo_value (signed)
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfo_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lfo_pkg::*;

  // Configuration registers
  logic [PHASE_W-1:0] phase_step_r, phase_offset_r;
  logic [2:0]         wave_sel_r;
  logic               key_trig_r;
  logic [15:0]        smooth_k_r, depth_r;

  // Oscillator state
  lfo_state_t                  state_r, state_nxt;
  logic [PHASE_W-1:0]          phase_r, phase_nxt;
  logic [31:0]                 lfsr_r, lfsr_nxt;
  logic signed [SAMPLE_W-1:0]  smooth_r;
  logic                        note_r;

  // Datapath registers
  logic signed [SAMPLE_W-1:0]  raw_r, raw_nxt;
  logic signed [SAMPLE_W-1:0]  scaled_r, scaled_nxt;
  logic signed [PROD_W-1:0]    prod_r, acc_r;
  logic signed [SAMPLE_W-1:0]  out_data_r, result;
  logic                        out_valid_r;

  // Shared multiplier
  logic signed [MUL_A_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]    mul_p;

  // Sequencer outputs
  logic in_take, out_load;

  // Wave generation scratch
  logic [PHASE_W-1:0]          phase_start, pn;
  logic [1:0]                  quad;
  logic [30:0]                 qpos;
  logic [SINE_IDX_W-1:0]       sine_idx;
  logic [SAMPLE_W-2:0]         sine_mag;
  logic signed [SAMPLE_W-1:0]  saw;
  logic signed [SAMPLE_W+1:0]  tri_wide;
  logic [31:0]                 lfsr_step;

  // Rounding and saturation
  logic signed [ACC_W-1:0]     depth_rnd, smooth_sum;
  logic signed [ACC_W-1:0]     smooth_rnd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= '0;
      phase_offset_r <= '0;
      wave_sel_r     <= WAVE_SINE;
      key_trig_r     <= 1'b0;
      smooth_k_r     <= '0;
      depth_r        <= DEPTH_UNITY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PHASE_STEP:   phase_step_r   <= cfg_data[PHASE_W-1:0];
        REG_PHASE_OFFSET: phase_offset_r <= cfg_data[PHASE_W-1:0];
        REG_WAVE_SELECT:  wave_sel_r     <= cfg_data[2:0];
        REG_KEY_TRIGGER:  key_trig_r     <= cfg_data[0];
        REG_SMOOTH_COEFF: smooth_k_r     <= cfg_data[15:0];
        REG_DEPTH_GAIN:   depth_r        <= cfg_data[15:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_WAVE;
      ST_WAVE:  state_nxt = ST_DEPTH;
      ST_DEPTH: state_nxt = ST_OLD;
      ST_OLD:   state_nxt = ST_NEW;
      ST_NEW:   state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and multiplier operand select
  always_comb begin
    in_tready = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_DEPTH: begin
        mul_a = MUL_A_W'(raw_r);
        mul_b = MUL_B_W'({1'b0, depth_r});
      end
      ST_OLD: begin
        mul_a = MUL_A_W'(smooth_r);
        mul_b = MUL_B_W'({1'b0, smooth_k_r});
      end
      ST_NEW: begin
        mul_a = MUL_A_W'(scaled_r);
        mul_b = MUL_B_W'(18'sd65536 - MUL_B_W'({1'b0, smooth_k_r}));
      end
      ST_DONE:  out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_take = in_tready && in_tvalid;
  assign mul_p   = mul_a * mul_b;

  // Waveform: clear phase on note-on when key trigger is set, then advance
  always_comb begin
    phase_start = (note_r && key_trig_r) ? '0 : phase_r;
    pn          = phase_start + phase_offset_r;
    quad        = pn[31:30];
    qpos        = quad[0] ? (31'h40000000 - {1'b0, pn[29:0]}) : {1'b0, pn[29:0]};
    sine_idx    = qpos[30:22];
    sine_mag    = SINE_ROM[sine_idx];
    saw         = $signed({~pn[31], pn[30:16]});
    tri_wide    = (saw[SAMPLE_W-1] ? -18'(saw) : 18'(saw)) * 18'sd2 - 18'sd32768;
    lfsr_step   = lfsr_r[0] ? ((lfsr_r >> 1) ^ LFSR_TAPS) : (lfsr_r >> 1);
    lfsr_nxt    = lfsr_r;
    phase_nxt   = phase_r;
    raw_nxt     = raw_r;
    if (state_r == ST_WAVE) begin
      phase_nxt = phase_start + phase_step_r;
      case (wave_sel_r)
        WAVE_SINE:
          raw_nxt = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});
        WAVE_TRIANGLE:
          raw_nxt = (tri_wide > 18'sd32767) ? VAL_MAX : SAMPLE_W'(tri_wide);
        WAVE_SAW:
          raw_nxt = saw;
        WAVE_SQUARE:
          raw_nxt = pn[31] ? VAL_MIN : VAL_MAX;
        WAVE_RANDOM, WAVE_HOLD: begin
          lfsr_nxt = lfsr_step;
          raw_nxt  = $signed({~lfsr_step[31], lfsr_step[30:16]});
        end
        default:
          raw_nxt = '0;
      endcase
    end
  end

  // Depth: round half up at bit 15, saturate
  always_comb begin
    depth_rnd  = (ACC_W'(prod_r) + ACC_W'(36'sd16384)) >>> 15;
    scaled_nxt = scaled_r;
    if (state_r == ST_OLD) begin
      if (depth_rnd > ACC_W'(36'sd32767))       scaled_nxt = VAL_MAX;
      else if (depth_rnd < ACC_W'(-36'sd32768)) scaled_nxt = VAL_MIN;
      else                                      scaled_nxt = SAMPLE_W'(depth_rnd);
    end
  end

  // Smoother: old*k + new*(1-k), round at bit 16, saturate; k of zero bypasses
  always_comb begin
    smooth_sum = ACC_W'(acc_r) + ACC_W'(prod_r);
    smooth_rnd = (smooth_sum + ACC_W'(36'sd32768)) >>> 16;
    if (smooth_k_r == '0)                      result = scaled_r;
    else if (smooth_rnd > ACC_W'(36'sd32767))  result = VAL_MAX;
    else if (smooth_rnd < ACC_W'(-36'sd32768)) result = VAL_MIN;
    else                                       result = SAMPLE_W'(smooth_rnd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      lfsr_r      <= LFSR_SEED;
      smooth_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      lfsr_r   <= lfsr_nxt;
      if (out_load) begin
        smooth_r    <= result;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) note_r <= in_tdata[0];
    raw_r    <= raw_nxt;
    scaled_r <= scaled_nxt;
    if (state_r == ST_DEPTH || state_r == ST_OLD || state_r == ST_NEW) begin
      prod_r <= mul_p;
    end
    if (state_r == ST_NEW) acc_r <= prod_r;
    if (out_load) out_data_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
